// ===== rtl/mpt_pkg.sv =====
package mpt_pkg;

   localparam int ValueWidth = 30;
   localparam int StepCountWidth = 5;

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [StepCountWidth-1:0] step_count_type;

   // Moduli: the prime and its totient
   localparam value_type PrimeMod = 30'd1000000007;
   localparam value_type TotientMod = 30'd1000000006;

   // Last bit position of a 30-bit operand or exponent
   localparam step_count_type LastStep = step_count_type'(ValueWidth - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

   // Control from the sequencer to one bit-serial multiplier
   typedef struct packed {
      logic start;
      logic sel_prime;
   } mul_ctl_type;

   // One compare and subtract: valid for any v below twice m
   function automatic value_type reduce_once(input value_type v, input value_type m);
      value_type r;
      r = (v >= m) ? value_type'(v - m) : v;
      return r;
   endfunction

endpackage

// ===== rtl/mpt_modmul.sv =====
module mpt_modmul (
   input  logic                clock,
   input  logic                reset,
   input  mpt_pkg::mul_ctl_type ctl,
   input  mpt_pkg::value_type  mcand,
   input  mpt_pkg::value_type  mplier,
   output logic                done,
   output mpt_pkg::value_type  product
);
   import mpt_pkg::*;

   value_type      acc_ff, acc_in;
   value_type      mcand_ff, mcand_in;
   value_type      mplier_ff, mplier_in;
   step_count_type cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           sel_ff, sel_in;

   value_type         modulus;
   logic [ValueWidth:0] dbl;
   value_type         dbl_red;
   logic [ValueWidth:0] sum;
   value_type         sum_red;

   // One multiplier bit per cycle, most significant first: acc = 2*acc + bit*mcand mod m
   always_comb begin
      modulus = sel_ff ? PrimeMod : TotientMod;
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? ValueWidth'(dbl - {1'b0, modulus})
                                         : ValueWidth'(dbl);
      sum     = {1'b0, dbl_red} + (mplier_ff[ValueWidth-1] ? {1'b0, mcand_ff}
                                                            : {(ValueWidth+1){1'b0}});
      sum_red = (sum >= {1'b0, modulus}) ? ValueWidth'(sum - {1'b0, modulus})
                                         : ValueWidth'(sum);
   end

   // Load on start, advance while busy
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      sel_in    = sel_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
         sel_in    = ctl.sel_prime;
      end else if (busy_ff) begin
         acc_in    = sum_red;
         mplier_in = {mplier_ff[ValueWidth-2:0], 1'b0};
         cnt_in    = step_count_type'(cnt_ff + 1'b1);
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      sel_ff    <= sel_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/modular_power_tower.sv =====
// Computes a^(b^c) mod 1000000007 for each request: first r = b^c mod 1000000006, then
// a^r mod 1000000007, both by right-to-left square-and-multiply over a fixed 30 exponent
// bits. Each exponent bit runs a square and a conditional multiply side by side on two
// bit-serial modular multipliers. A request is taken only while the block is idle, so no
// new request enters until the last result is loaded into the output register; the next
// request is taken the cycle after that load, even if that result has not yet been taken.
module modular_power_tower (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [29:0] base, [59:30] inner_base, [89:60] inner_exponent, [95:90] zero
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [29:0] power_result, [31:30] zero
   output logic [31:0] rsp_tdata
);
   import mpt_pkg::*;

   state_type      state_ff, state_in;
   value_type      acc_ff, acc_in;
   value_type      sq_ff, sq_in;
   value_type      exp_ff, exp_in;
   value_type      outer_ff, outer_in;
   step_count_type step_ff, step_in;
   logic           outer_pass_ff, outer_pass_in;
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      rsp_data_ff, rsp_data_in;

   mul_ctl_type mul_ctl;
   logic        acc_done, sq_done;
   value_type   acc_prod, sq_prod;
   logic        req_fire, out_free;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Multiply unit: acc * sq
   mpt_modmul u_mul_acc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .mcand   (acc_ff),
      .mplier  (sq_ff),
      .done    (acc_done),
      .product (acc_prod)
   );

   // Square unit: sq * sq
   mpt_modmul u_mul_sq (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .mcand   (sq_ff),
      .mplier  (sq_ff),
      .done    (sq_done),
      .product (sq_prod)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (sq_done) begin
               if (step_ff == LastStep && outer_pass_ff) state_in = ST_DONE;
               else state_in = ST_START;
            end
         end
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready        = 1'b0;
      mul_ctl.start     = 1'b0;
      mul_ctl.sel_prime = outer_pass_ff;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_START: mul_ctl.start = 1'b1;
         ST_WAIT,
         ST_DONE:  ;
         default:  ;
      endcase
   end

   // Datapath: load operands, step the exponent, switch passes, hold the result
   always_comb begin
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      exp_in        = exp_ff;
      outer_in      = outer_ff;
      step_in       = step_ff;
      outer_pass_in = outer_pass_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (req_fire) begin
         outer_in      = reduce_once(req_tdata[29:0], PrimeMod);
         sq_in         = reduce_once(req_tdata[59:30], TotientMod);
         exp_in        = req_tdata[89:60];
         acc_in        = value_type'(1);
         step_in       = '0;
         outer_pass_in = 1'b0;
      end else if (state_ff == ST_WAIT && sq_done) begin
         if (exp_ff[0]) acc_in = acc_prod;
         sq_in   = sq_prod;
         exp_in  = {1'b0, exp_ff[ValueWidth-1:1]};
         step_in = step_count_type'(step_ff + 1'b1);
         if (step_ff == LastStep && !outer_pass_ff) begin
            // Inner result becomes the outer exponent
            exp_in        = exp_ff[0] ? acc_prod : acc_ff;
            sq_in         = outer_ff;
            acc_in        = value_type'(1);
            step_in       = '0;
            outer_pass_in = 1'b1;
         end
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
         outer_pass_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         outer_pass_ff <= outer_pass_in;
      end
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      exp_ff      <= exp_in;
      outer_ff    <= outer_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // Both units are started together and must finish together
   a_units_in_step: assert property (@(posedge clock) disable iff (reset)
      acc_done == sq_done)
      else $error("multiply and square units out of step");

   // A result is always reduced below the prime
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff < PrimeMod))
      else $error("result not reduced");

   // Units only finish while the sequencer waits for them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_WAIT))
      else $error("multiplier finished outside wait state");

   // A start always leads to waiting
   a_start_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |=> (state_ff == ST_WAIT))
      else $error("start not followed by wait");

endmodule
